FILE: sv/log_strain_principal_stress_moduli_core_defines.svh
// ----------------------------------------------------------------------------
// log strain principal stress core: assertion macros
// concurrent assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef LOG_STRAIN_PRINCIPAL_STRESS_MODULI_CORE_DEFINES_SVH
`define LOG_STRAIN_PRINCIPAL_STRESS_MODULI_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define LSP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lsp assertion failed");

// next-cycle implication, off during reset
`define LSP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lsp assertion failed");

// next-cycle implication, always on
`define LSP_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lsp assertion failed");

`endif

FILE: sv/lsp_pkg.sv
// ----------------------------------------------------------------------------
// log strain principal stress package
// shared widths, codes and types
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned SQ_STEPS = 24;
  localparam int unsigned E_W      = 29;
  localparam int unsigned SUM_W    = 31;
  localparam int unsigned N_W      = 64;
  localparam int unsigned QUO_W    = 48;
  localparam int unsigned DIV_LAT  = QUO_W + 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MU     = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SAT    = 2'd1,
    ST_DOMAIN = 2'd2
  } status_t;

  typedef struct packed {
    logic vld;
    logic zero;
  } tag_t;

  typedef logic [IN_W-1:0]         stretch_t;
  typedef logic signed [E_W-1:0]   strain_t;
  typedef logic signed [OUT_W-1:0] res_t;

endpackage

`default_nettype wire

FILE: sv/lsp_chan_if.sv
// ----------------------------------------------------------------------------
// log strain principal stress channels
// input and result valid/ready interfaces
// ----------------------------------------------------------------------------
`default_nettype none

interface lsp_in_if;
  logic valid;
  logic ready;
  logic [lsp_pkg::IN_W-1:0] stretch_sq_a;
  logic [lsp_pkg::IN_W-1:0] stretch_sq_b;
  logic [lsp_pkg::IN_W-1:0] stretch_sq_c;

  modport source (output valid, stretch_sq_a, stretch_sq_b, stretch_sq_c, input ready);
  modport sink (input valid, stretch_sq_a, stretch_sq_b, stretch_sq_c, output ready);
endinterface

interface lsp_out_if;
  logic valid;
  logic ready;
  logic [lsp_pkg::OUT_W-1:0] stress_a;
  logic [lsp_pkg::OUT_W-1:0] stress_b;
  logic [lsp_pkg::OUT_W-1:0] stress_c;
  logic [lsp_pkg::OUT_W-1:0] modulus_aa;
  logic [lsp_pkg::OUT_W-1:0] modulus_bb;
  logic [lsp_pkg::OUT_W-1:0] modulus_cc;
  logic [lsp_pkg::OUT_W-1:0] modulus_ab;
  logic [lsp_pkg::OUT_W-1:0] modulus_ac;
  logic [lsp_pkg::OUT_W-1:0] modulus_bc;
  logic [1:0]                status_code;

  modport source (output valid, stress_a, stress_b, stress_c, modulus_aa, modulus_bb,
                  modulus_cc, modulus_ab, modulus_ac, modulus_bc, status_code,
                  input ready);
  modport sink (input valid, stress_a, stress_b, stress_c, modulus_aa, modulus_bb,
                modulus_cc, modulus_ab, modulus_ac, modulus_bc, status_code,
                output ready);
endinterface

`default_nettype wire

FILE: sv/lsp_log2.sv
// ----------------------------------------------------------------------------
// lsp half natural log pipeline
// three lanes: normalise, 24 squaring stages, ln2 scale and round
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_log2 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lsp_pkg::tag_t     tag_in,
  input  lsp_pkg::stretch_t x_in  [3],
  output lsp_pkg::tag_t     tag_out,
  output lsp_pkg::stretch_t x_out [3],
  output lsp_pkg::strain_t  e_out [3]
);

  localparam int unsigned LN = 3;
  localparam int unsigned SQ = lsp_pkg::SQ_STEPS;
  localparam int unsigned FW = lsp_pkg::FRAC_W;

  function automatic logic [4:0] msb_idx(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  logic [31:0]       nm_m_r   [LN];
  logic [4:0]        nm_p_r   [LN];
  lsp_pkg::stretch_t nm_x_r   [LN];
  lsp_pkg::tag_t     nm_tag_r;

  logic [31:0]       sq_m_r   [SQ][LN];
  logic [FW-1:0]     sq_f_r   [SQ][LN];
  logic [4:0]        sq_p_r   [SQ][LN];
  lsp_pkg::stretch_t sq_x_r   [SQ][LN];
  lsp_pkg::tag_t     sq_tag_r [SQ];

  logic [60:0]       pr_mag_r [LN];
  logic              pr_neg_r [LN];
  lsp_pkg::stretch_t pr_x_r   [LN];
  lsp_pkg::tag_t     pr_tag_r;

  lsp_pkg::strain_t  e_r      [LN];
  lsp_pkg::stretch_t ex_r     [LN];
  lsp_pkg::tag_t     e_tag_r;

  logic [31:0]       nm_m_nxt [LN];
  logic [4:0]        nm_p_nxt [LN];
  logic [31:0]       sq_m_nxt [SQ][LN];
  logic [FW-1:0]     sq_f_nxt [SQ][LN];
  logic [60:0]       pr_mag_nxt [LN];
  logic              pr_neg_nxt [LN];
  lsp_pkg::strain_t  e_nxt    [LN];

  always_comb begin
    logic [31:0]    src_m;
    logic [FW-1:0]  src_f;
    logic [63:0]    prod;
    logic [32:0]    t;
    logic [5:0]     pe;
    logic [29:0]    lg;
    logic [29:0]    mag;
    logic [61:0]    rs;
    logic [28:0]    rr;
    for (int l = 0; l < LN; l++) begin
      nm_p_nxt[l] = msb_idx(x_in[l]);
      nm_m_nxt[l] = x_in[l] << (5'd31 - nm_p_nxt[l]);
    end
    for (int j = 0; j < SQ; j++) begin
      for (int l = 0; l < LN; l++) begin
        src_m = (j == 0) ? nm_m_r[l] : sq_m_r[(j == 0) ? 0 : j - 1][l];
        src_f = (j == 0) ? '0 : sq_f_r[(j == 0) ? 0 : j - 1][l];
        prod  = 64'(src_m) * 64'(src_m);
        t     = prod[63:31];
        sq_m_nxt[j][l] = t[32] ? t[32:1] : t[31:0];
        sq_f_nxt[j][l] = {src_f[FW-2:0], t[32]};
      end
    end
    for (int l = 0; l < LN; l++) begin
      pe  = {1'b0, sq_p_r[SQ-1][l]} - 6'd24;
      lg  = {pe, sq_f_r[SQ-1][l]};
      mag = lg[29] ? (30'd0 - lg) : lg;
      pr_neg_nxt[l] = lg[29];
      pr_mag_nxt[l] = 61'(mag[28:0]) * 61'(lsp_pkg::LN2_Q32);
      rs  = {1'b0, pr_mag_r[l]} + (62'd1 << 32);
      rr  = rs[61:33];
      e_nxt[l] = pr_neg_r[l] ? (29'd0 - rr) : rr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_tag_r <= '0;
      for (int j = 0; j < SQ; j++) sq_tag_r[j] <= '0;
      pr_tag_r <= '0;
      e_tag_r  <= '0;
    end else if (en) begin
      nm_tag_r    <= tag_in;
      sq_tag_r[0] <= nm_tag_r;
      for (int j = 1; j < SQ; j++) sq_tag_r[j] <= sq_tag_r[j-1];
      pr_tag_r <= sq_tag_r[SQ-1];
      e_tag_r  <= pr_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LN; l++) begin
        nm_m_r[l] <= nm_m_nxt[l];
        nm_p_r[l] <= nm_p_nxt[l];
        nm_x_r[l] <= x_in[l];
        sq_p_r[0][l] <= nm_p_r[l];
        sq_x_r[0][l] <= nm_x_r[l];
        for (int j = 0; j < SQ; j++) begin
          sq_m_r[j][l] <= sq_m_nxt[j][l];
          sq_f_r[j][l] <= sq_f_nxt[j][l];
        end
        for (int j = 1; j < SQ; j++) begin
          sq_p_r[j][l] <= sq_p_r[j-1][l];
          sq_x_r[j][l] <= sq_x_r[j-1][l];
        end
        pr_mag_r[l] <= pr_mag_nxt[l];
        pr_neg_r[l] <= pr_neg_nxt[l];
        pr_x_r[l]   <= sq_x_r[SQ-1][l];
        e_r[l]      <= e_nxt[l];
        ex_r[l]     <= pr_x_r[l];
      end
    end
  end

  assign tag_out = e_tag_r;
  assign x_out   = ex_r;
  assign e_out   = e_r;

endmodule

`default_nettype wire

FILE: sv/lsp_div.sv
// ----------------------------------------------------------------------------
// lsp pipelined divider
// restoring division, one quotient bit a stage, rounded and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_div #(
  parameter int unsigned DW = 71,
  parameter int unsigned VW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic          neg,
  input  logic [VW-1:0] den,
  output lsp_pkg::res_t quo,
  output logic          sat
);

  localparam int unsigned QW = lsp_pkg::QUO_W;
  localparam int unsigned HW = DW - QW;
  localparam int unsigned CW = (HW > VW) ? HW : VW;
  localparam int unsigned NS = QW + 1;
  localparam logic [QW:0] NEG_LIM = (QW+1)'(1) << (QW - 1);
  localparam logic [QW:0] POS_LIM = NEG_LIM - (QW+1)'(1);
  localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

  logic [VW-1:0] rem_r [NS];
  logic [QW-1:0] low_r [NS];
  logic [QW-1:0] q_r   [NS];
  logic [VW-1:0] den_r [NS];
  logic          neg_r [NS];
  logic          ovf_r [NS];
  lsp_pkg::res_t quo_r;
  logic          sat_r;

  logic [VW-1:0] rem_nxt [NS];
  logic [QW-1:0] low_nxt [NS];
  logic [QW-1:0] q_nxt   [NS];
  logic          ovf_nxt;
  logic [QW-1:0] quo_nxt;
  logic          sat_nxt;

  always_comb begin
    logic [VW:0] trial;
    logic        ge;
    logic [VW:0] dbl;
    logic [QW:0] q1;
    rem_nxt[0] = VW'(num[DW-1:QW]);
    low_nxt[0] = num[QW-1:0];
    q_nxt[0]   = '0;
    ovf_nxt    = CW'(num[DW-1:QW]) >= CW'(den);
    for (int j = 1; j < NS; j++) begin
      trial      = {rem_r[j-1], low_r[j-1][QW-1]};
      ge         = trial >= {1'b0, den_r[j-1]};
      rem_nxt[j] = ge ? VW'(trial - {1'b0, den_r[j-1]}) : VW'(trial);
      low_nxt[j] = {low_r[j-1][QW-2:0], 1'b0};
      q_nxt[j]   = {q_r[j-1][QW-2:0], ge};
    end
    dbl = {rem_r[NS-1], 1'b0};
    q1  = {1'b0, q_r[NS-1]} + {{QW{1'b0}}, (dbl >= {1'b0, den_r[NS-1]})};
    sat_nxt = ovf_r[NS-1] || (q1 > (neg_r[NS-1] ? NEG_LIM : POS_LIM));
    if (sat_nxt) begin
      quo_nxt = neg_r[NS-1] ? SAT_NEG : SAT_POS;
    end else begin
      quo_nxt = neg_r[NS-1] ? ({QW{1'b0}} - q1[QW-1:0]) : q1[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      neg_r[0] <= neg;
      ovf_r[0] <= ovf_nxt;
      for (int j = 0; j < NS; j++) begin
        rem_r[j] <= rem_nxt[j];
        low_r[j] <= low_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
      for (int j = 1; j < NS; j++) begin
        den_r[j] <= den_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
      quo_r <= quo_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign quo = quo_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

FILE: sv/log_strain_principal_stress_moduli_core.sv
// ----------------------------------------------------------------------------
// log strain principal stress and moduli core
// hencky law in principal directions, fixed point, fully pipelined
// ----------------------------------------------------------------------------
// Accepts one transaction of three stretches squared every clock while no
// result waits, and returns one result transaction per input after the log
// pipeline (with its 24 squaring stages), the registered stages forming
// strains, stresses numerators and divisors, and the nine dividers (one
// quotient bit per stage). The whole pipeline holds while a result waits to be taken.
// The user writes lambda and mu through the cfg port while the core is empty; unenforced.
`default_nettype none

module log_strain_principal_stress_moduli_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsp_pkg::CFG_W-1:0]       cfg_data,
  lsp_in_if.sink                          in_ch,
  lsp_out_if.source                       out_ch
);

  localparam int unsigned DL = lsp_pkg::DIV_LAT;
  localparam int unsigned NW = lsp_pkg::N_W;

  logic [31:0] lam_r;
  logic [31:0] mu_r;

  logic en;
  lsp_pkg::tag_t     in_tag;
  lsp_pkg::stretch_t in_x [3];
  lsp_pkg::tag_t     lg_tag;
  lsp_pkg::stretch_t lg_x [3];
  lsp_pkg::strain_t  lg_e [3];

  lsp_pkg::tag_t s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  lsp_pkg::tag_t dv_tag_r [DL];

  logic signed [lsp_pkg::SUM_W-1:0] s1_sum_r;
  lsp_pkg::strain_t  s1_e_r [3];
  lsp_pkg::stretch_t s1_s_r [3], s2_s_r [3], s3_s_r [3], s4_s_r [3];
  logic [63:0]       s1_sq_r [3], s2_sq_r [3], s3_sq_r [3], s4_sq_r [3];
  logic [63:0]       s1_xy_r [3], s2_xy_r [3], s3_xy_r [3], s4_xy_r [3];
  logic signed [NW-1:0] s2_plam_r;
  logic signed [NW-1:0] s2_pmu_r [3];
  logic signed [NW-1:0] s2_base_r, s3_base_r;
  logic signed [NW-1:0] s3_n_r [3], s4_n_r [3];
  logic signed [NW-1:0] s4_d_r [3];

  logic [70:0] st_num [3];
  logic        st_neg [3];
  logic [95:0] dg_num [3];
  logic        dg_neg [3];
  lsp_pkg::res_t res [9];
  logic [8:0]    res_sat;
  logic [63:0]   mag_n [3];
  logic [63:0]   mag_d [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= '0;
      mu_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lsp_pkg::CFG_LAMBDA: lam_r <= cfg_data;
        lsp_pkg::CFG_MU:     mu_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en          = !dv_tag_r[DL-1].vld || out_ch.ready;
  assign in_ch.ready = en;
  assign in_x[0]     = in_ch.stretch_sq_a;
  assign in_x[1]     = in_ch.stretch_sq_b;
  assign in_x[2]     = in_ch.stretch_sq_c;
  assign in_tag.vld  = in_ch.valid;
  assign in_tag.zero = (in_ch.stretch_sq_a == '0) || (in_ch.stretch_sq_b == '0) ||
                       (in_ch.stretch_sq_c == '0);

  lsp_log2 u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_in  (in_tag),
    .x_in    (in_x),
    .tag_out (lg_tag),
    .x_out   (lg_x),
    .e_out   (lg_e)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
      s4_tag_r <= '0;
      for (int j = 0; j < DL; j++) dv_tag_r[j] <= '0;
    end else if (en) begin
      s1_tag_r    <= lg_tag;
      s2_tag_r    <= s1_tag_r;
      s3_tag_r    <= s2_tag_r;
      s4_tag_r    <= s3_tag_r;
      dv_tag_r[0] <= s4_tag_r;
      for (int j = 1; j < DL; j++) dv_tag_r[j] <= dv_tag_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum_r   <= lsp_pkg::SUM_W'(lg_e[0]) + lsp_pkg::SUM_W'(lg_e[1]) +
                    lsp_pkg::SUM_W'(lg_e[2]);
      s1_xy_r[0] <= 64'(lg_x[0]) * 64'(lg_x[1]);
      s1_xy_r[1] <= 64'(lg_x[0]) * 64'(lg_x[2]);
      s1_xy_r[2] <= 64'(lg_x[1]) * 64'(lg_x[2]);
      s2_plam_r  <= $signed({1'b0, lam_r}) * s1_sum_r;
      s2_base_r  <= {6'd0, ({2'b00, lam_r} + {1'b0, mu_r, 1'b0}), 24'd0};
      s3_base_r  <= s2_base_r;
      for (int i = 0; i < 3; i++) begin
        s1_e_r[i]  <= lg_e[i];
        s1_s_r[i]  <= lg_x[i];
        s1_sq_r[i] <= 64'(lg_x[i]) * 64'(lg_x[i]);
        s2_pmu_r[i] <= $signed({1'b0, mu_r, 1'b0}) * s1_e_r[i];
        s3_n_r[i]  <= s2_plam_r + s2_pmu_r[i];
        s4_n_r[i]  <= s3_n_r[i];
        s4_d_r[i]  <= s3_base_r - (s3_n_r[i] <<< 1);
        s2_s_r[i]  <= s1_s_r[i];
        s3_s_r[i]  <= s2_s_r[i];
        s4_s_r[i]  <= s3_s_r[i];
        s2_sq_r[i] <= s1_sq_r[i];
        s3_sq_r[i] <= s2_sq_r[i];
        s4_sq_r[i] <= s3_sq_r[i];
        s2_xy_r[i] <= s1_xy_r[i];
        s3_xy_r[i] <= s2_xy_r[i];
        s4_xy_r[i] <= s3_xy_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      st_neg[i] = s4_n_r[i][NW-1];
      mag_n[i]  = st_neg[i] ? (64'd0 - s4_n_r[i]) : s4_n_r[i];
      st_num[i] = {mag_n[i][62:0], 8'd0};
      dg_neg[i] = s4_d_r[i][NW-1];
      mag_d[i]  = dg_neg[i] ? (64'd0 - s4_d_r[i]) : s4_d_r[i];
      dg_num[i] = {mag_d[i], 32'd0};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    lsp_div #(.DW(71), .VW(32)) u_stress (
      .clk (clk),
      .en  (en),
      .num (st_num[i]),
      .neg (st_neg[i]),
      .den (s4_s_r[i]),
      .quo (res[i]),
      .sat (res_sat[i])
    );
    lsp_div #(.DW(96), .VW(64)) u_diag (
      .clk (clk),
      .en  (en),
      .num (dg_num[i]),
      .neg (dg_neg[i]),
      .den (s4_sq_r[i]),
      .quo (res[3+i]),
      .sat (res_sat[3+i])
    );
    lsp_div #(.DW(88), .VW(64)) u_couple (
      .clk (clk),
      .en  (en),
      .num ({lam_r, 56'd0}),
      .neg (1'b0),
      .den (s4_xy_r[i]),
      .quo (res[6+i]),
      .sat (res_sat[6+i])
    );
  end

  always_comb begin
    lsp_pkg::status_t st;
    if (dv_tag_r[DL-1].zero) begin
      st = lsp_pkg::ST_DOMAIN;
    end else if (|res_sat) begin
      st = lsp_pkg::ST_SAT;
    end else begin
      st = lsp_pkg::ST_OK;
    end
    out_ch.status_code = st;
  end

  assign out_ch.valid      = dv_tag_r[DL-1].vld;
  assign out_ch.stress_a   = dv_tag_r[DL-1].zero ? '0 : res[0];
  assign out_ch.stress_b   = dv_tag_r[DL-1].zero ? '0 : res[1];
  assign out_ch.stress_c   = dv_tag_r[DL-1].zero ? '0 : res[2];
  assign out_ch.modulus_aa = dv_tag_r[DL-1].zero ? '0 : res[3];
  assign out_ch.modulus_bb = dv_tag_r[DL-1].zero ? '0 : res[4];
  assign out_ch.modulus_cc = dv_tag_r[DL-1].zero ? '0 : res[5];
  assign out_ch.modulus_ab = dv_tag_r[DL-1].zero ? '0 : res[6];
  assign out_ch.modulus_ac = dv_tag_r[DL-1].zero ? '0 : res[7];
  assign out_ch.modulus_bc = dv_tag_r[DL-1].zero ? '0 : res[8];

endmodule

`default_nettype wire

FILE: sv/lsp_checker.sv
// ----------------------------------------------------------------------------
// lsp port checker
// port-level assertions, bound to the core
// ----------------------------------------------------------------------------
`default_nettype none

`include "log_strain_principal_stress_moduli_core_defines.svh"

module lsp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_status,
  input logic [lsp_pkg::OUT_W-1:0] out_stress_a,
  input logic [lsp_pkg::OUT_W-1:0] out_modulus_ab
);

  logic in_seen;
  assign in_seen = in_valid;

  // stalled result holds
  `LSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_stress_a) && $stable(out_status))

  // input side moves exactly when the result side frees up
  `LSP_ASSERT_IMPL(a_ready_link, clk, rst_n, in_seen || !in_seen, in_ready == (!out_valid || out_ready))

  // domain error clears the payload
  `LSP_ASSERT_IMPL(a_domain_zero, clk, rst_n, out_valid && (out_status == lsp_pkg::ST_DOMAIN), (out_stress_a == '0) && (out_modulus_ab == '0))

  // pipeline empty after reset
  `LSP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind log_strain_principal_stress_moduli_core lsp_checker u_lsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status_code),
  .out_stress_a   (out_ch.stress_a),
  .out_modulus_ab (out_ch.modulus_ab)
);

`default_nettype wire
